// ===== design/video_ram_port_with_autoinc_assert.svh =====
// Assertion macros shared by the video RAM port modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef VIDEO_RAM_PORT_WITH_AUTOINC_ASSERT_SVH
`define VIDEO_RAM_PORT_WITH_AUTOINC_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only out of reset.
`define VRP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vrp assertion failed");
// Checked at every edge, reset included.
`define VRP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("vrp assertion failed");
`else
`define VRP_ASSERT(label, prop)
`define VRP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== design/vrp_pkg.sv =====
// Shared types and constants for the video RAM port.
// No dependencies.
package vrp_pkg;

  localparam int unsigned MEMORY_BYTES  = 32768;
  localparam int unsigned MEM_AW        = $clog2(MEMORY_BYTES);
  localparam int unsigned SCREEN_HEIGHT = 192;
  localparam int unsigned COL_W         = 7;
  localparam int unsigned ROW_W         = 8;

  // Register address bits
  localparam int unsigned ADDR_PORT_BIT = 2;
  localparam int unsigned ADDR_DATA_BIT = 1;
  localparam int unsigned ADDR_ADV_BIT  = 0;

  localparam logic [7:0] STATUS_BYTE = 8'hFF;
  localparam logic [7:0] LEVEL_FULL  = 8'd255;
  localparam logic [7:0] LEVEL_HALF  = 8'd127;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PIXEL = 2'd2
  } mode_e;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic clear;     // clearing pass write
    logic accept;    // input beat taken this cycle
    logic out_load;  // stage 1 moves into the output register
  } vrp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_last;
  } vrp_sts_t;

endpackage

// ===== design/vrp_if.sv =====
// Valid/ready channel interfaces for the video RAM port.
// No dependencies.
interface vrp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] address;
  logic [7:0] write_data;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;

  modport source (output valid, mode, address, write_data, pixel_x, pixel_y, input ready);
  modport sink   (input valid, mode, address, write_data, pixel_x, pixel_y, output ready);
endinterface

interface vrp_out_if;
  logic       valid;
  logic       ready;
  logic       is_pixel;
  logic [7:0] read_data;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, is_pixel, read_data, red, green, blue, input ready);
  modport sink   (input valid, is_pixel, read_data, red, green, blue, output ready);
endinterface

// ===== design/vrp_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module vrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/vrp_ctrl.sv =====
// Controller: clearing pass / run state, pipeline valid bits, handshakes.
// Depends on vrp_pkg and the assertion header.
`include "video_ram_port_with_autoinc_assert.svh"

module vrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vrp_pkg::vrp_cmd_t cmd_o,
  input  vrp_pkg::vrp_sts_t sts_i
);
  import vrp_pkg::*;

  state_e state_q, state_d;
  logic   s1_valid_q, s1_valid_d;
  logic   out_valid_q, out_valid_d;
  logic   adv;
  logic   accept;
  logic   has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    adv        = !out_valid_q || out_ready_i;
    case (mode_i)
      MODE_READ, MODE_PIXEL: has_result = 1'b1;
      default:               has_result = 1'b0;
    endcase
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        in_ready_o = adv;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    accept         = in_valid_i && in_ready_o;
    cmd_o.accept   = accept;
    cmd_o.out_load = adv && s1_valid_q;
    s1_valid_d     = adv ? (accept && has_result) : s1_valid_q;
    out_valid_d    = adv ? s1_valid_q : out_valid_q;
  end

  assign out_valid_o = out_valid_q;

  `VRP_ASSERT(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !in_ready_o)
  `VRP_ASSERT(a_result_enters_s1, (accept && has_result) |=> s1_valid_q)
  `VRP_ASSERT(a_s1_holds_on_stall, (s1_valid_q && !adv) |=> s1_valid_q)
  `VRP_ASSERT(a_clear_ends, (state_q == ST_CLEAR && sts_i.clear_last) |=> (state_q == ST_RUN))

endmodule

// ===== design/vrp_dp.sv =====
// Datapath: pointers, clear counter, video RAM, result stage and output register.
// Depends on vrp_pkg, vrp_ram and the assertion header.
`include "video_ram_port_with_autoinc_assert.svh"

module vrp_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vrp_pkg::vrp_cmd_t cmd_i,
  output vrp_pkg::vrp_sts_t sts_o,
  input  logic [1:0]        mode_i,
  input  logic [2:0]        address_i,
  input  logic [7:0]        write_data_i,
  input  logic [7:0]        pixel_x_i,
  input  logic [7:0]        pixel_y_i,
  output logic              is_pixel_o,
  output logic [7:0]        read_data_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o
);
  import vrp_pkg::*;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [MEM_AW-1:0] clr_addr_q;

  logic [MEM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic              ram_we, ram_re;

  logic is_port, is_data, is_adv;
  logic is_read, is_write, is_pix;
  logic on_screen;

  // Stage 1 payload: what to do with the RAM read data
  logic s1_pixel_q, s1_mem_q, s1_black_q, s1_hi_q;

  logic [3:0] nib;
  logic [7:0] level;

  logic       is_pixel_q;
  logic [7:0] read_data_q, red_q, green_q, blue_q;

  assign is_port   = address_i[ADDR_PORT_BIT];
  assign is_data   = address_i[ADDR_DATA_BIT];
  assign is_adv    = address_i[ADDR_ADV_BIT];
  assign is_read   = (mode_i == MODE_READ);
  assign is_write  = (mode_i == MODE_WRITE);
  assign is_pix    = (mode_i == MODE_PIXEL);
  assign on_screen = ({1'b0, pixel_y_i} < 9'(SCREEN_HEIGHT));

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (clr_addr_q == {MEM_AW{1'b1}});

  // Pointer updates
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.accept && (is_read || is_write)) begin
      if (is_port) begin
        if (is_adv) begin
          col_d = col_q + 1'b1;
          if (col_q == {COL_W{1'b1}}) begin
            row_d = row_q + 1'b1;
          end
        end
      end else if (is_write) begin
        if (is_data) begin
          row_d = write_data_i;
        end
        if (is_adv) begin
          col_d = write_data_i[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // RAM port
  always_comb begin
    if (cmd_i.clear) begin
      ram_addr = clr_addr_q;
    end else if (is_pix) begin
      ram_addr = MEM_AW'({pixel_y_i, pixel_x_i[7:1]});
    end else begin
      ram_addr = MEM_AW'({row_q, col_q});
    end
    ram_wdata = cmd_i.clear ? 8'h00 : write_data_i;
    ram_we    = cmd_i.clear || (cmd_i.accept && is_write && is_port && is_data);
    ram_re    = cmd_i.accept && ((is_read && is_port && is_data) || (is_pix && on_screen));
  end

  vrp_ram #(
    .WIDTH (8),
    .DEPTH (MEMORY_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1_pixel_q <= is_pix;
      s1_mem_q   <= is_port && is_data;
      s1_black_q <= !on_screen;
      s1_hi_q    <= pixel_x_i[0];
    end
  end

  // Nibble to RGB
  assign nib   = s1_hi_q ? ram_rdata[7:4] : ram_rdata[3:0];
  assign level = nib[3] ? LEVEL_FULL : LEVEL_HALF;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      is_pixel_q <= s1_pixel_q;
      if (s1_pixel_q) begin
        read_data_q <= 8'h00;
        red_q       <= (nib[2] && !s1_black_q) ? level : 8'h00;
        green_q     <= (nib[1] && !s1_black_q) ? level : 8'h00;
        blue_q      <= (nib[0] && !s1_black_q) ? level : 8'h00;
      end else begin
        read_data_q <= s1_mem_q ? ram_rdata : STATUS_BYTE;
        red_q       <= 8'h00;
        green_q     <= 8'h00;
        blue_q      <= 8'h00;
      end
    end
  end

  assign is_pixel_o  = is_pixel_q;
  assign read_data_o = read_data_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  `VRP_ASSERT(a_pixel_keeps_pointers, (cmd_i.accept && is_pix) |=> ($stable(col_q) && $stable(row_q)))
  `VRP_ASSERT(a_clear_writes, cmd_i.clear |-> (ram_we && !ram_re))
  `VRP_ASSERT_ALWAYS(a_no_accept_with_clear, !(cmd_i.clear && cmd_i.accept))

endmodule

// ===== design/video_ram_port_with_autoinc.sv =====
// Top level of the video RAM port with auto-incrementing pointers.
// Depends on vrp_pkg, vrp_if, vrp_ctrl and vrp_dp.

// After reset the block sweeps its 32 KiB video memory to zero, one byte a
// cycle; in_i.ready stays low until that pass is done. After that it takes
// one beat per cycle on in_i unless out_o stalls: bus reads (mode 0), bus
// writes (mode 1) and pixel fetches (mode 2). Each beat makes at most one
// access on the single RAM port, so the RAM port sets the rate at one beat a
// cycle. Reads and pixel fetches give one result beat on out_o, through the
// RAM read register and then the output register; writes and mode 3 give
// none. A write followed by a read of the same byte returns the new byte.
// Pointers advance at the edge the beat is taken, so the next beat always
// sees them. When out_o stalls, the pipe holds and in_i.ready drops until
// the output register is taken.
module video_ram_port_with_autoinc (
  input logic      clk_i,
  input logic      rst_ni,
  vrp_in_if.sink   in_i,
  vrp_out_if.source out_o
);
  import vrp_pkg::*;

  vrp_cmd_t cmd;
  vrp_sts_t sts;

  // State machine and valid bits
  vrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .mode_i      (in_i.mode),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Pointers, memory and the result path
  vrp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (in_i.mode),
    .address_i    (in_i.address),
    .write_data_i (in_i.write_data),
    .pixel_x_i    (in_i.pixel_x),
    .pixel_y_i    (in_i.pixel_y),
    .is_pixel_o   (out_o.is_pixel),
    .read_data_o  (out_o.read_data),
    .red_o        (out_o.red),
    .green_o      (out_o.green),
    .blue_o       (out_o.blue)
  );

endmodule

// ===== tb/vrp_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the video RAM port testbench: VRAM and pointer model plus
// the queue of awaited result beats. Depends on vrp_pkg.
package vrp_tb_pkg;
  import vrp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Register addresses: bit2 port, bit1 data/row, bit0 advance/column
  localparam logic [2:0] REG_LOAD_NONE     = 3'd0;
  localparam logic [2:0] REG_LOAD_COL      = 3'd1;
  localparam logic [2:0] REG_LOAD_ROW      = 3'd2;
  localparam logic [2:0] REG_LOAD_BOTH     = 3'd3;
  localparam logic [2:0] REG_PORT_HOLD     = 3'd4;
  localparam logic [2:0] REG_PORT_ADV      = 3'd5;
  localparam logic [2:0] REG_PORT_DATA     = 3'd6;
  localparam logic [2:0] REG_PORT_DATA_ADV = 3'd7;

  typedef struct packed {
    logic       is_pixel;
    logic [7:0] read_data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } vrp_beat_t;

  class vram_scoreboard;
    logic [7:0]       vram_model [MEMORY_BYTES];
    logic [COL_W-1:0] col_ptr;
    logic [ROW_W-1:0] row_ptr;
    vrp_beat_t        awaited [$];
    int unsigned      errors;

    function new();
      foreach (vram_model[i]) vram_model[i] = '0;
      col_ptr = '0;
      row_ptr = '0;
      errors  = 0;
    endfunction

    function logic [7:0] level(logic [3:0] nib, int unsigned sel);
      if (!nib[sel]) return '0;
      return nib[3] ? LEVEL_FULL : LEVEL_HALF;
    endfunction

    // column carries into the row, row wraps
    function void advance();
      {row_ptr, col_ptr} = {row_ptr, col_ptr} + 15'd1;
    endfunction

    function void note_beat(logic [1:0] mode, logic [2:0] addr, logic [7:0] wdata,
                            logic [7:0] px, logic [7:0] py);
      vrp_beat_t  beat;
      logic [7:0] pix_byte;
      logic [3:0] nib;
      beat = '0;
      case (mode)
        MODE_READ: begin
          beat.read_data = STATUS_BYTE;
          if (addr[ADDR_PORT_BIT]) begin
            if (addr[ADDR_DATA_BIT]) beat.read_data = vram_model[{row_ptr, col_ptr}];
            if (addr[ADDR_ADV_BIT]) advance();
          end
          awaited.push_back(beat);
        end
        MODE_WRITE: begin
          if (addr[ADDR_PORT_BIT]) begin
            if (addr[ADDR_DATA_BIT]) vram_model[{row_ptr, col_ptr}] = wdata;
            if (addr[ADDR_ADV_BIT]) advance();
          end else begin
            if (addr[ADDR_DATA_BIT]) row_ptr = wdata;
            if (addr[ADDR_ADV_BIT]) col_ptr = wdata[COL_W-1:0];
          end
        end
        MODE_PIXEL: begin
          beat.is_pixel = 1'b1;
          if (py < SCREEN_HEIGHT) begin
            pix_byte   = vram_model[{py, px[7:1]}];
            nib        = px[0] ? pix_byte[7:4] : pix_byte[3:0];
            beat.red   = level(nib, 2);
            beat.green = level(nib, 1);
            beat.blue  = level(nib, 0);
          end
          awaited.push_back(beat);
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_beat(vrp_beat_t got);
      vrp_beat_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result beat expected none got %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("is_pixel", 8'(want.is_pixel), 8'(got.is_pixel));
      compare("read_data", want.read_data, got.read_data);
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
    endfunction

    function void flag_leftovers();
      if (awaited.size() != 0) begin
        $display("%0t: %0d result beats expected got none", $time, awaited.size());
        errors += awaited.size();
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the video RAM port testbench: clock, reset, beat drivers, stimulus
// and watchdog. Depends on vrp_pkg, vrp_if, vrp_tb_pkg and the DUT.
module tb;
  import vrp_pkg::*;
  import vrp_tb_pkg::*;

  // The clearing pass after reset is the longest stretch with no beat at all.
  localparam int unsigned WATCHDOG_LIMIT = 4 * MEMORY_BYTES;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned TAIL_CYCLES    = 8;   // two-stage pipe plus margin

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vrp_in_if  in_bus ();
  vrp_out_if out_bus ();

  vram_scoreboard sb;

  bit          calm;         // no idling on either side while set
  bit          hold_req;     // sink owes one long hold-off
  int unsigned issued;       // beats that the block acts on
  int unsigned idle_cycles;

  video_ram_port_with_autoinc dut (
    .clk_i,
    .rst_ni,
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one beat after a random gap and hold it until taken. Valid stays
  // high across back-to-back beats so it never gets two updates in a step.
  task automatic send(logic [1:0] mode, logic [2:0] addr, logic [7:0] wdata,
                      logic [7:0] px, logic [7:0] py);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= mode;
    in_bus.address    <= addr;
    in_bus.write_data <= wdata;
    in_bus.pixel_x    <= px;
    in_bus.pixel_y    <= py;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_beat(mode, addr, wdata, px, py);
    if (mode != MODE_UNUSED) issued++;
  endtask

  // Sender pause: stop offering until every awaited beat has come back.
  // The first edge is always taken so valid is not touched twice in a step.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  // Load row and column in one of three ways; the column write carries a
  // random bit 7 that the block must drop.
  task automatic load_pointers(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    logic [7:0] col_byte;
    col_byte = {1'($urandom_range(0, 1)), col};
    case ($urandom_range(0, 2))
      0: begin
        send(MODE_WRITE, REG_LOAD_BOTH, row, 8'($urandom), 8'($urandom));
        send(MODE_WRITE, REG_LOAD_COL, col_byte, 8'($urandom), 8'($urandom));
      end
      1: begin
        send(MODE_WRITE, REG_LOAD_ROW, row, 8'($urandom), 8'($urandom));
        send(MODE_WRITE, REG_LOAD_COL, col_byte, 8'($urandom), 8'($urandom));
      end
      default: begin
        send(MODE_WRITE, REG_LOAD_COL, col_byte, 8'($urandom), 8'($urandom));
        send(MODE_WRITE, REG_LOAD_ROW, row, 8'($urandom), 8'($urandom));
      end
    endcase
  endtask

  // Well-formed use: point, write a run of bytes with auto-advance, point
  // again, read the run back, then scan the same bytes out as pixels.
  task automatic pointer_sequence();
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [14:0]      spot;
    logic [1:0]       op;
    int unsigned      len;
    case ($urandom_range(0, 3))
      0:       row = 8'($urandom_range(0, 3));          // small area, lots of reuse
      1:       row = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
      2:       row = 8'($urandom_range(250, 255));      // wrap of the row pointer
      default: row = 8'($urandom);
    endcase
    col = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(120, 127)) : 7'($urandom);
    len = $urandom_range(1, 10);
    load_pointers(row, col);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send(MODE_WRITE, REG_PORT_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
        send(MODE_WRITE, REG_PORT_ADV, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send(MODE_WRITE, REG_PORT_DATA_ADV, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    load_pointers(row, col);
    for (int unsigned k = 0; k < len; k++) begin
      // a read at the advance-only address returns status and still steps
      op = MODE_READ;
      if ($urandom_range(0, 3) == 0) begin
        send(op, REG_PORT_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
        send(op, REG_PORT_ADV, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send(op, REG_PORT_DATA_ADV, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    for (int unsigned k = 0; k < 2 * len; k++) begin
      spot = {row, col} + 15'(k / 2);
      send(MODE_PIXEL, 3'($urandom), 8'($urandom), {spot[6:0], k[0]}, spot[14:7]);
    end
  endtask

  // Anything at all, unused mode included.
  task automatic noise(int unsigned count);
    for (int unsigned k = 0; k < count; k++)
      send(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Result sink: random hold-off before each beat, or one long hold-off when
  // asked, counted here so the block fills and backs up its input.
  initial begin : result_sink
    int unsigned hold;
    vrp_beat_t   got;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold     = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 7);
      end
      if (hold != 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
      got.is_pixel  = out_bus.is_pixel;
      got.read_data = out_bus.read_data;
      got.red       = out_bus.red;
      got.green     = out_bus.green;
      got.blue      = out_bus.blue;
      sb.check_beat(got);
    end
  end

  initial begin : stimulus
    int unsigned seq_count;
    sb = new();
    in_bus.valid      <= 1'b0;
    in_bus.mode       <= MODE_READ;
    in_bus.address    <= REG_LOAD_NONE;
    in_bus.write_data <= '0;
    in_bus.pixel_x    <= '0;
    in_bus.pixel_y    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Status reads at low addresses and at the port without
    // the data bit; cleared memory reads zero.
    send(MODE_READ, REG_LOAD_NONE, 8'h00, 8'h00, 8'h00);
    send(MODE_READ, REG_LOAD_BOTH, 8'hFF, 8'hFF, 8'hFF);
    send(MODE_READ, REG_PORT_HOLD, 8'h00, 8'h00, 8'h00);
    send(MODE_READ, REG_PORT_DATA, 8'h00, 8'h00, 8'h00);
    // Last byte of memory, then write-then-read of it and the full wrap of
    // both pointers back to the first byte.
    send(MODE_WRITE, REG_LOAD_BOTH, 8'hFF, 8'h00, 8'h00);
    send(MODE_WRITE, REG_PORT_DATA, 8'hA5, 8'h00, 8'h00);
    send(MODE_READ, REG_PORT_DATA_ADV, 8'h00, 8'h00, 8'h00);
    send(MODE_READ, REG_PORT_DATA, 8'h00, 8'h00, 8'h00);
    // Two bytes whose nibbles cover full and half intensity in each color.
    send(MODE_WRITE, REG_PORT_DATA_ADV, 8'h9C, 8'h00, 8'h00);
    send(MODE_WRITE, REG_PORT_DATA_ADV, 8'h7E, 8'h00, 8'h00);
    // Writes that touch nothing, advance alone, read-advance alone.
    send(MODE_WRITE, REG_LOAD_NONE, 8'h55, 8'h00, 8'h00);
    send(MODE_WRITE, REG_PORT_HOLD, 8'hAA, 8'h00, 8'h00);
    send(MODE_WRITE, REG_PORT_ADV, 8'h00, 8'h00, 8'h00);
    send(MODE_READ, REG_PORT_ADV, 8'h00, 8'h00, 8'h00);
    // Column load drops bit 7.
    send(MODE_WRITE, REG_LOAD_ROW, 8'h00, 8'h00, 8'h00);
    send(MODE_WRITE, REG_LOAD_COL, 8'h80, 8'h00, 8'h00);
    send(MODE_READ, REG_PORT_DATA_ADV, 8'h00, 8'h00, 8'h00);
    // Pixels: low and high nibble of both bytes, the last visible pixel,
    // rows below the screen (the last one over a nonzero byte).
    send(MODE_PIXEL, REG_LOAD_NONE, 8'h00, 8'd0, 8'd0);
    send(MODE_PIXEL, REG_LOAD_NONE, 8'h00, 8'd1, 8'd0);
    send(MODE_PIXEL, REG_PORT_DATA_ADV, 8'h00, 8'd2, 8'd0);
    send(MODE_PIXEL, REG_LOAD_NONE, 8'h00, 8'd3, 8'd0);
    send(MODE_PIXEL, REG_LOAD_NONE, 8'h00, 8'd255, 8'(SCREEN_HEIGHT - 1));
    send(MODE_PIXEL, REG_LOAD_NONE, 8'h00, 8'd0, 8'(SCREEN_HEIGHT));
    send(MODE_PIXEL, REG_LOAD_NONE, 8'h00, 8'd255, 8'd255);
    // Unused mode must leave pointers and memory alone.
    send(MODE_UNUSED, REG_PORT_DATA_ADV, 8'hFF, 8'hFF, 8'hFF);
    send(MODE_READ, REG_PORT_DATA, 8'h00, 8'h00, 8'h00);

    // Random part: mostly well-formed pointer sequences, some noise, one
    // long sink hold-off and one sender pause.
    issued    = 0;
    seq_count = 0;
    while (issued < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if (seq_count == 8) begin
        hold_req = 1'b1;
        calm     = 1'b1;
        for (int unsigned k = 0; k < 16; k++)
          send(MODE_READ, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      if (seq_count == 30) wait_drained();
      if ($urandom_range(0, 9) < 7) pointer_sequence();
      else noise($urandom_range(1, 4));
      seq_count++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/vrp_pkg.sv
design/vrp_if.sv
design/vrp_ram.sv
design/vrp_ctrl.sv
design/vrp_dp.sv
design/video_ram_port_with_autoinc.sv
tb/vrp_tb_pkg.sv
tb/tb.sv
